// ----- src/point_in_polygon_test_defines.svh -----
// Assertion macros for the point-in-polygon test block
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

// Next-cycle implication, checked outside reset
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt assertion failed");

`endif

// ----- src/ppt_pkg.sv -----
// Shared types and constants for the point-in-polygon test block
package ppt_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 5;
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int MIN_VERTICES = 3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } ppt_state_t;

    typedef struct packed {
        logic              capture;   // latch test point, clear flag and pipeline
        logic              wr_en;     // write one vertex
        logic [VIDX_W-1:0] wr_addr;
        logic              rd_en;     // read one vertex
        logic              rd_prime;  // read only seeds the previous vertex
        logic [VIDX_W-1:0] rd_addr;
    } ppt_cmd_t;

endpackage

// ----- src/point_in_polygon_test.sv -----
// Point-in-polygon test, even-odd crossing rule, vertex table of 16 entries.
// Load: accepted when idle, no result; busy stays low.
// Query: done pulses after a sweep over the n vertices in use (n capped at 16) and a drain,
// busy through done; a new query is accepted only after the block returns to idle.
// Below three vertices done follows in the next cycle, with no sweep.
// Async active-low reset clears control and vertex count; table is not cleared.
`include "point_in_polygon_test_defines.svh"
module point_in_polygon_test (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic [3:0]                vertex_index,
    input  logic signed [15:0]        coord_x,
    input  logic signed [15:0]        coord_y,
    output logic                      done,
    output logic                      inside_res,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ppt_pkg::CNT_W-1:0] cfg_data
);
    import ppt_pkg::*;

    ppt_cmd_t cmd;
    logic     flag;

    ppt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .vertex_index (vertex_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done)
    );

    ppt_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .flag    (flag)
    );

    assign inside_res = flag;

    `PPT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `PPT_ASSERT_NEXT(a_load_no_busy, clk, rst_n, start && !busy && (mode == MODE_LOAD), !busy && !done)
    `PPT_ASSERT_IMPLY(a_read_in_query, clk, rst_n, cmd.rd_en, busy && !done && !cmd.wr_en)
    `PPT_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (mode == MODE_QUERY), busy)

endmodule

// ----- src/ppt_dp.sv -----
// Datapath: vertex memory, edge crossing pipeline and inside flag
module ppt_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppt_pkg::ppt_cmd_t              cmd,
    input  logic signed [ppt_pkg::COORD_W-1:0] coord_x,
    input  logic signed [ppt_pkg::COORD_W-1:0] coord_y,
    output logic                           flag
);
    import ppt_pkg::*;

    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic                      a_any_reg, a_edge_reg;

    logic signed [PROD_W-1:0]  lhs_reg, rhs_reg;
    logic                      b_valid_reg, b_dypos_reg;
    logic                      flag_reg, flag_next;

    logic                      above_i, above_j, straddle;
    logic signed [DIFF_W-1:0]  dx, dy, ex, ey;
    logic signed [PROD_W-1:0]  lhs, rhs;
    logic                      left;

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_x[cmd.wr_addr] <= coord_x;
            mem_y[cmd.wr_addr] <= coord_y;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[cmd.rd_addr];
            rd_y_reg <= mem_y[cmd.rd_addr];
        end
    end

    // test point and previous vertex
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (a_any_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
    end

    // edge i = current read, j = previous vertex
    always_comb
    begin
        above_i  = rd_y_reg > py_reg;
        above_j  = prev_y_reg > py_reg;
        straddle = above_i != above_j;
        dx  = {prev_x_reg[COORD_W-1], prev_x_reg} - {rd_x_reg[COORD_W-1], rd_x_reg};
        dy  = {prev_y_reg[COORD_W-1], prev_y_reg} - {rd_y_reg[COORD_W-1], rd_y_reg};
        ex  = {px_reg[COORD_W-1], px_reg} - {rd_x_reg[COORD_W-1], rd_x_reg};
        ey  = {py_reg[COORD_W-1], py_reg} - {rd_y_reg[COORD_W-1], rd_y_reg};
        lhs = ex * dy;
        rhs = dx * ey;
    end

    always_ff @(posedge clk)
    begin
        lhs_reg     <= lhs;
        rhs_reg     <= rhs;
        // on a straddling edge dy is positive exactly when vertex j is above
        b_dypos_reg <= above_j;
    end

    always_comb
    begin
        left      = b_dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
        flag_next = flag_reg;
        if (cmd.capture)
            flag_next = 1'b0;
        else if (b_valid_reg && left)
            flag_next = ~flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_any_reg   <= 1'b0;
            a_edge_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            a_any_reg   <= cmd.rd_en;
            a_edge_reg  <= cmd.rd_en && !cmd.rd_prime;
            b_valid_reg <= a_edge_reg && straddle && !cmd.capture;
            flag_reg    <= flag_next;
        end
    end

    assign flag = flag_reg;

endmodule

// ----- src/ppt_ctrl.sv -----
// Controller: vertex count register and query sequencing
module ppt_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      mode,
    input  logic [3:0]                vertex_index,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ppt_pkg::CNT_W-1:0] cfg_data,
    output ppt_pkg::ppt_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);
    import ppt_pkg::*;

    ppt_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              drain_reg, drain_next;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  rd_sel;
    logic              accept, query, few, slot_ok;

    assign n_eff   = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_reg;
    assign few     = n_eff < CNT_W'(MIN_VERTICES);
    assign accept  = start && (state_reg == ST_IDLE);
    assign query   = accept && (mode == MODE_QUERY);
    assign slot_ok = {1'b0, vertex_index} < (VIDX_W + 1)'(MAX_VERTICES);
    // first read seeds the last vertex, then walk 0..n-1
    assign rd_sel  = (idx_reg == '0) ? (n_eff - CNT_W'(1)) : (idx_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                drain_next = 1'b0;
                if (query)
                    state_next = few ? ST_DONE : ST_SWEEP;
            end
            ST_SWEEP:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == n_eff)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        busy         = 1'b1;
        done         = 1'b0;
        cmd.wr_addr  = VIDX_W'(vertex_index);
        cmd.rd_addr  = rd_sel[VIDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = query;
                cmd.wr_en   = accept && (mode == MODE_LOAD) && slot_ok;
            end
            ST_SWEEP:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_prime = idx_reg == '0;
            end
            ST_DRAIN:
                busy = 1'b1;
            ST_DONE:
                done = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    assign cfg_ready = state_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ----- test/tb_point_in_polygon_test.sv -----
// Testbench for the point-in-polygon block: random vertex loads and point queries vs a predictor
module tb_point_in_polygon_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ppt_pkg::*;

    localparam int RUN_ITEMS   = 925;
    localparam int IDLE_SETTLE = 4;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 50;

    typedef enum logic [1:0] {
        STEP_TRANSFER,
        STEP_CONFIG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic                       mode;
        logic [3:0]                 slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [CNT_W-1:0]           count;
    } pending_step_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic                      busy;
    logic                      mode         = MODE_LOAD;
    logic [3:0]                vertex_index = '0;
    logic signed [15:0]        coord_x      = '0;
    logic signed [15:0]        coord_y      = '0;
    logic                      done;
    logic                      inside_res;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CNT_W-1:0]          cfg_data     = '0;

    pending_step_t             pending_steps[$];
    logic                      expected_inside[$];

    // predictor state
    logic signed [COORD_W-1:0] poly_x[MAX_VERTICES];
    logic signed [COORD_W-1:0] poly_y[MAX_VERTICES];
    logic [CNT_W-1:0]          poly_count;

    // stimulus-side copy of the loaded vertices, used to aim queries at vertex heights
    logic signed [COORD_W-1:0] planned_y[MAX_VERTICES];
    int                        item_total;

    int                        mismatch_count;
    int                        cycle_count;

    point_in_polygon_test i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .done         (done),
        .inside_res   (inside_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // even-odd crossing count, exact cross-multiplied intercept test
    function automatic logic crossing_parity(input logic signed [COORD_W-1:0] px,
                                             input logic signed [COORD_W-1:0] py);
        int     n;
        int     j;
        longint xi;
        longint yi;
        longint xj;
        longint yj;
        longint dy;
        longint lhs;
        longint rhs;
        logic   flag;
        logic   left;
        n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        flag = 1'b0;
        if (n < MIN_VERTICES)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > longint'(py)) != (yj > longint'(py)))
            begin
                dy   = yj - yi;
                lhs  = (longint'(px) - xi) * dy;
                rhs  = (xj - xi) * (longint'(py) - yi);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                flag ^= left;
            end
            j = i;
        end
        return flag;
    endfunction

    task automatic push_load(input int slot, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        pending_step_t s;
        s       = '{STEP_TRANSFER, MODE_LOAD, slot[3:0], x, y, '0};
        planned_y[slot] = y;
        pending_steps = {pending_steps, s};
        item_total++;
    endtask

    task automatic push_query(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        pending_step_t s;
        s = '{STEP_TRANSFER, MODE_QUERY, 4'($urandom_range(0, 15)), x, y, '0};
        pending_steps = {pending_steps, s};
        item_total++;
    endtask

    task automatic push_config(input int count);
        pending_step_t s;
        s = '{STEP_CONFIG, MODE_LOAD, '0, '0, '0, count[CNT_W-1:0]};
        pending_steps = {pending_steps, s};
    endtask

    task automatic push_drain();
        pending_step_t s;
        s = '{STEP_DRAIN, MODE_LOAD, '0, '0, '0, '0};
        pending_steps = {pending_steps, s};
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
        logic [31:0] r;
        int          v;
        r = $urandom();
        if (span >= 32768)
            return r[15:0];
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return $urandom_range(0, 2);
        if (r < 4)
            return $urandom_range(17, 31);
        return $urandom_range(3, 16);
    endfunction

    // driver: one transaction or one register write at a time
    always @(posedge clk or negedge rst_n)
    begin
        int  gap_left;
        int  settle;
        logic launch;
        logic cfg_launch;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            settle     = 0;
            poly_count = '0;
        end
        else
        begin
            launch     = start;
            cfg_launch = cfg_valid;
            if (start && !busy)
            begin
                if (mode == MODE_LOAD)
                begin
                    poly_x[vertex_index] = coord_x;
                    poly_y[vertex_index] = coord_y;
                end
                else
                    expected_inside = {expected_inside, crossing_parity(coord_x, coord_y)};
                launch = 1'b0;
                if (pending_steps.size() > 120 && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 16);
            end
            if (cfg_valid && cfg_ready)
            begin
                poly_count = cfg_data;
                cfg_launch = 1'b0;
            end
            if (!launch && !cfg_launch)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_steps.size() > 0)
                begin
                    if (pending_steps[0].kind == STEP_TRANSFER)
                    begin
                        mode         <= pending_steps[0].mode;
                        vertex_index <= pending_steps[0].slot;
                        coord_x      <= pending_steps[0].x;
                        coord_y      <= pending_steps[0].y;
                        launch       = 1'b1;
                        void'(pending_steps.pop_front());
                    end
                    else
                    begin
                        // hold until the block is idle and every result is in
                        if (busy || expected_inside.size() != 0)
                            settle = 0;
                        else
                            settle++;
                        if (settle >= IDLE_SETTLE)
                        begin
                            settle = 0;
                            if (pending_steps[0].kind == STEP_CONFIG)
                            begin
                                cfg_data   <= pending_steps[0].count;
                                cfg_launch = 1'b1;
                            end
                            void'(pending_steps.pop_front());
                        end
                    end
                end
            end
            start     <= launch;
            cfg_valid <= cfg_launch;
        end
    end

    // monitor: results cannot be stalled, take each one on its strobe
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && done)
        begin
            if (expected_inside.size() == 0)
                report_mismatch($sformatf("unexpected result inside_res=%0b", inside_res));
            else
            begin
                want = expected_inside.pop_front();
                if (inside_res !== want)
                    report_mismatch($sformatf("inside_res=%0b, predicted %0b",
                                              inside_res, want));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int span;
        int nload;
        int nquery;
        int r;
        int s;
        mismatch_count = 0;
        cycle_count    = 0;
        item_total     = 0;
        foreach (planned_y[k])
            planned_y[k] = '0;

        // directed: reset count of zero reads no vertex
        push_query(16'sd0, 16'sd0);
        push_load(0, -16'sd16384, -16'sd16384);
        push_load(1,  16'sd16384, -16'sd16384);
        push_load(2,  16'sd16384,  16'sd16384);
        push_load(3, -16'sd16384,  16'sd16384);
        push_load(4,  16'sd32767, -16'sd32768);
        push_load(5, -16'sd32768,  16'sd32767);
        push_load(6,  16'sd32767,  16'sd32767);
        push_load(7, -16'sd32768, -16'sd32768);
        for (int k = 8; k < MAX_VERTICES; k++)
            push_load(k, 16'(k * 1000 - 5000), 16'(3000 - k * 500));
        push_config(4);
        push_query(16'sd0, 16'sd0);
        push_query(16'sd16384, 16'sd0);
        push_query(-16'sd20000, 16'sd16384);
        push_query(16'sd32767, -16'sd32768);
        push_config(2);
        push_query(16'sd0, 16'sd0);
        push_config(31);
        push_query(16'sd0, 16'sd0);
        push_query(-16'sd32768, 16'sd32767);
        push_config(16);
        push_query(16'sd100, -16'sd100);

        // random phases: a fresh polygon in a box, then queries, most aimed at that box, with some reloads
        while (item_total < RUN_ITEMS)
        begin
            span = 1 << $urandom_range(3, 15);
            if ($urandom_range(0, 3) == 0)
                push_drain();
            push_config(pick_count());
            nload = $urandom_range(0, 16);
            for (int k = 0; k < nload; k++)
                push_load($urandom_range(0, 15), pick_coord(span), pick_coord(span));
            nquery = $urandom_range(4, 24);
            for (int k = 0; k < nquery; k++)
            begin
                r = $urandom_range(0, 9);
                s = $urandom_range(0, 15);
                if (r == 0)
                    push_load(s, pick_coord(span), pick_coord(span));
                else if (r == 1)
                    push_query(pick_coord(32768), pick_coord(32768));
                else if (r == 2)
                    push_query(pick_coord(span), planned_y[s]);
                else
                    push_query(pick_coord(span), pick_coord(span));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() != 0 || start || cfg_valid || expected_inside.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
